FILE: rtl/core/mrb_pkg.sv
package mrb_pkg;

   typedef logic [1:0] op_type;
   typedef logic [1:0] status_type;

   localparam int MRB_SLOTS      = 16;
   localparam int MRB_SLOT_BYTES = 32;
   localparam int MRB_MAX_USERS  = 255;

   localparam op_type OP_OPEN  = 2'd0;
   localparam op_type OP_CLOSE = 2'd1;
   localparam op_type OP_WRITE = 2'd2;
   localparam op_type OP_READ  = 2'd3;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_WOULDBLOCK = 2'd1;
   localparam status_type ST_NO_PARTNER = 2'd2;

   localparam int LENGTH_W = 6;
   localparam int COUNT_W  = 5;
   localparam int USERS_W  = 8;
   localparam int BYTE_W   = 8;

endpackage

FILE: rtl/core/message_ring_buffer_core.sv
// open, close and every write word are taken back to back while the output register is free; the
// result (if any) sits in the output register in the cycle after the word is taken
// read: first byte passes the slot length memory read, then the payload memory read, into
// the output register, then one byte per cycle while the output is not stalled; a read holds
// the input stalled until its last byte is loaded into the output register
// synchronous active-high reset empties the ring and clears the user counts; no clearing pass
module message_ring_buffer_core #(
   parameter int SLOTS      = mrb_pkg::MRB_SLOTS,
   parameter int SLOT_BYTES = mrb_pkg::MRB_SLOT_BYTES,
   parameter int MAX_USERS  = mrb_pkg::MRB_MAX_USERS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mrb_pkg::op_type                   req_operation,
   input  logic                              req_for_reading,
   input  logic                              req_for_writing,
   input  logic [mrb_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                              req_byte_present,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mrb_pkg::status_type               rsp_status,
   output logic [mrb_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic                              rsp_out_byte_valid,
   output logic                              rsp_end_of_run,
   output logic [mrb_pkg::LENGTH_W-1:0]      rsp_length,
   output logic [mrb_pkg::COUNT_W-1:0]       rsp_item_count,
   output logic [mrb_pkg::USERS_W-1:0]       rsp_reader_count,
   output logic [mrb_pkg::USERS_W-1:0]       rsp_writer_count
);
   import mrb_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int PW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
   localparam int FW = $clog2(SLOT_BYTES + 1);
   localparam int HW = $clog2(SLOTS + 1);
   localparam int UW = $clog2(MAX_USERS + 1);
   localparam int AW = SW + PW;
   localparam int PAY_DEPTH = SLOTS << PW;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LEN    = 2'd1;
   localparam logic [1:0] ST_STREAM = 2'd2;

   // memories
   logic [BYTE_W-1:0] payload_mem [PAY_DEPTH];
   logic [FW-1:0]     len_mem [SLOTS];
   logic [BYTE_W-1:0] pay_rdata_ff;
   logic [FW-1:0]     len_rdata_ff;

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] head_ff, head_in;
   logic [SW-1:0] tail_ff, tail_in;
   logic [HW-1:0] held_ff, held_in;
   logic [UW-1:0] readers_ff, readers_in;
   logic [UW-1:0] writers_ff, writers_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic          rej_ff, rej_in;
   logic [SW-1:0] rd_slot_ff, rd_slot_in;
   logic [FW-1:0] run_len_ff, run_len_in;
   logic [FW-1:0] emit_idx_ff, emit_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_bv_ff, rsp_bv_in;
   logic               rsp_end_ff, rsp_end_in;
   logic [LENGTH_W-1:0] rsp_len_ff, rsp_len_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [USERS_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic [USERS_W-1:0] rsp_wr_ff, rsp_wr_in;

   logic          out_free;
   logic          req_accept;
   logic          out_load;
   logic          pay_we;
   logic [AW-1:0] pay_waddr;
   logic          pay_rd_en;
   logic [AW-1:0] pay_raddr;
   logic          len_we;
   logic          len_rd_en;
   logic [FW-1:0] len_clamped;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && out_free);
   assign req_accept = req_valid && !req_stall;
   assign len_clamped = (len_rdata_ff > FW'(SLOT_BYTES)) ? FW'(SLOT_BYTES) : len_rdata_ff;

   always_comb begin
      logic          rej_now;
      logic [FW-1:0] fill_next;
      logic          run_end;
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      held_in     = held_ff;
      readers_in  = readers_ff;
      writers_in  = writers_ff;
      fill_in     = fill_ff;
      rej_in      = rej_ff;
      rd_slot_in  = rd_slot_ff;
      run_len_in  = run_len_ff;
      emit_idx_in = emit_idx_ff;
      out_load    = 1'b0;
      rsp_status_in = ST_OK;
      rsp_byte_in   = '0;
      rsp_bv_in     = 1'b0;
      rsp_end_in    = 1'b1;
      rsp_len_in    = '0;
      pay_we    = 1'b0;
      pay_waddr = {tail_ff, fill_ff[PW-1:0]};
      pay_rd_en = 1'b0;
      pay_raddr = {rd_slot_ff, PW'(0)};
      len_we    = 1'b0;
      len_rd_en = 1'b0;
      rej_now   = rej_ff || (fill_ff == '0 && held_ff >= HW'(SLOTS));
      fill_next = fill_ff;
      run_end   = (FW'(emit_idx_ff + 1'b1) == run_len_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_operation)
                  OP_OPEN: begin
                     if (req_for_reading && readers_ff < UW'(MAX_USERS))
                        readers_in = readers_ff + 1'b1;
                     if (req_for_writing && writers_ff < UW'(MAX_USERS))
                        writers_in = writers_ff + 1'b1;
                     out_load = 1'b1;
                  end
                  OP_CLOSE: begin
                     if (req_for_reading && readers_ff != '0)
                        readers_in = readers_ff - 1'b1;
                     if (req_for_writing && writers_ff != '0)
                        writers_in = writers_ff - 1'b1;
                     out_load = 1'b1;
                  end
                  OP_WRITE: begin
                     rej_in = rej_now;
                     // overlong messages keep their first SLOT_BYTES bytes
                     if (!rej_now && req_byte_present && fill_ff < FW'(SLOT_BYTES)) begin
                        pay_we    = 1'b1;
                        fill_next = fill_ff + 1'b1;
                     end
                     fill_in = fill_next;
                     if (req_last) begin
                        out_load = 1'b1;
                        fill_in  = '0;
                        rej_in   = 1'b0;
                        if (rej_now) begin
                           rsp_status_in = (readers_ff == '0) ? ST_NO_PARTNER : ST_WOULDBLOCK;
                        end else begin
                           len_we     = 1'b1;
                           tail_in    = (tail_ff == SW'(SLOTS - 1)) ? '0 : tail_ff + 1'b1;
                           held_in    = held_ff + 1'b1;
                           rsp_len_in = LENGTH_W'(fill_next);
                        end
                     end
                  end
                  OP_READ: begin
                     if (held_ff == '0) begin
                        out_load      = 1'b1;
                        rsp_status_in = (writers_ff == '0) ? ST_NO_PARTNER : ST_WOULDBLOCK;
                     end else begin
                        len_rd_en  = 1'b1;
                        rd_slot_in = head_ff;
                        head_in    = (head_ff == SW'(SLOTS - 1)) ? '0 : head_ff + 1'b1;
                        held_in    = held_ff - 1'b1;
                        state_in   = ST_LEN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_LEN: begin
            if (len_clamped == '0) begin
               if (out_free) begin
                  out_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               // fetch the first byte; the stream state keeps one byte in flight
               pay_rd_en   = 1'b1;
               run_len_in  = len_clamped;
               emit_idx_in = '0;
               state_in    = ST_STREAM;
            end
         end
         ST_STREAM: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_byte_in = pay_rdata_ff;
               rsp_bv_in   = 1'b1;
               rsp_end_in  = run_end;
               rsp_len_in  = LENGTH_W'(run_len_ff);
               if (run_end) begin
                  state_in = ST_IDLE;
               end else begin
                  pay_rd_en   = 1'b1;
                  pay_raddr   = {rd_slot_ff, PW'(emit_idx_ff + 1'b1)};
                  emit_idx_in = emit_idx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_cnt_in   = COUNT_W'(held_in);
      rsp_rd_in    = USERS_W'(readers_in);
      rsp_wr_in    = USERS_W'(writers_in);
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (pay_we)
         payload_mem[pay_waddr] <= req_data_byte;
      if (pay_rd_en)
         pay_rdata_ff <= payload_mem[pay_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we)
         len_mem[tail_ff] <= fill_in == '0 ? (req_last ? fill_ff + FW'(pay_we) : '0) : '0;
      if (len_rd_en)
         len_rdata_ff <= len_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         held_ff      <= '0;
         readers_ff   <= '0;
         writers_ff   <= '0;
         fill_ff      <= '0;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         held_ff      <= held_in;
         readers_ff   <= readers_in;
         writers_ff   <= writers_in;
         fill_ff      <= fill_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff  <= rd_slot_in;
      run_len_ff  <= run_len_in;
      emit_idx_ff <= emit_idx_in;
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_bv_ff     <= rsp_bv_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_cnt_ff    <= rsp_cnt_in;
         rsp_rd_ff     <= rsp_rd_in;
         rsp_wr_ff     <= rsp_wr_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_out_byte_valid = rsp_bv_ff;
   assign rsp_end_of_run     = rsp_end_ff;
   assign rsp_length         = rsp_len_ff;
   assign rsp_item_count     = rsp_cnt_ff;
   assign rsp_reader_count   = rsp_rd_ff;
   assign rsp_writer_count   = rsp_wr_ff;

   held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HW'(SLOTS))
      else $error("ring holds more messages than slots");

   fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(SLOT_BYTES))
      else $error("fill position past slot size");

   reject_clean: assert property (@(posedge clock) disable iff (reset)
      rej_ff |-> fill_ff == '0)
      else $error("rejected message stored bytes");

   busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("input taken during a read run");

   stream_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STREAM |-> emit_idx_ff < run_len_ff)
      else $error("stream index past message length");

endmodule
